@@ rtl/core/lca_pkg.sv @@
// lca_pkg: shared types, action codes and datapath commands for the
// binary lifting lca engine. No dependencies.
`default_nettype none

package lca_pkg;

    localparam int NODE_W = 10;
    localparam int LVL_W  = 4;
    localparam int ACT_W  = 2;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LVL_W-1:0]  lvl_t;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BUILD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_QCAPT,
        OP_RD_DA,
        OP_RD_DB,
        OP_SWAP,
        OP_L1_RD_ANC,
        OP_L1_RD_DEP,
        OP_L1_STEP,
        OP_P2_RD,
        OP_P2_STEP,
        OP_RES_A,
        OP_RES_ANC,
        OP_B_ISSUE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        node_t  node;
        lvl_t   level;
    } dp_cmd_t;

    typedef struct packed {
        logic  depth_ne;
        logic  a_eq_b;
        lvl_t  top_level;
        node_t last_node;
    } dp_stat_t;

    // highest node index that the tables hold
    function automatic node_t node_last(input int max_nodes);
        int lim;
        lim = (1 << NODE_W) - 1;
        return (max_nodes < lim) ? node_t'(max_nodes) : node_t'(lim);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lca_binary_lifting_engine.sv @@
// lca_binary_lifting_engine: top level of the binary lifting lca engine.
// Depends on lca_pkg, lca_ctrl and lca_datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  config   | cfg_we                | cfg_wdata (node_count)
//  input    | in_valid / in_stall   | action, node_a, node_b, node_depth
//  output   | out_valid / out_stall | ancestor
//
// after reset a clearing pass zeroes both tables, node by node and level by
// level, with the input stalled throughout.
// a load word is written without leaving the idle state; a query's
// depth-matching pass makes two reads per level.
// a build runs level by level, one node a cycle through a three-stage
// read-read-write pipeline drained between levels.
// a query result waits in the output register under out_stall; the block
// holds a finished query only when that register is still full.
`default_nettype none

module lca_binary_lifting_engine
    import lca_pkg::*;
#(
    parameter int MAX_NODES = 1023,
    parameter int LEVELS    = 10
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [NODE_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [NODE_W-1:0] node_a,
    input  wire logic [NODE_W-1:0] node_b,
    input  wire logic [NODE_W-1:0] node_depth,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [NODE_W-1:0]      ancestor
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lca_ctrl #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lca_datapath #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .node_a     (node_a),
        .node_b     (node_b),
        .node_depth (node_depth),
        .cmd        (cmd),
        .stat       (stat),
        .ancestor   (ancestor)
    );

endmodule

`default_nettype wire

@@ rtl/core/lca_datapath.sv @@
// lca_datapath: ancestor and depth memories, node_count register, query
// registers and the three-stage table build pipeline. Uses lca_pkg.
`default_nettype none

module lca_datapath
    import lca_pkg::*;
#(
    parameter int MAX_NODES = 1023,
    parameter int LEVELS    = 10
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire node_t        cfg_wdata,
    input  wire node_t        node_a,
    input  wire node_t        node_b,
    input  wire node_t        node_depth,
    input  wire dp_cmd_t      cmd,
    output dp_stat_t          stat,
    output node_t             ancestor
);

    localparam node_t NODE_LAST  = node_last(MAX_NODES);
    localparam lvl_t  LEVEL_LAST = lvl_t'(LEVELS - 1);
    localparam int    AW         = $clog2(int'(NODE_LAST) + 1);
    localparam int    LW         = $clog2(LEVELS);
    localparam int    ANC_DEPTH  = 1 << (AW + LW);
    localparam int    DEP_DEPTH  = 1 << AW;

    typedef logic [AW+LW-1:0] anc_addr_t;

    function automatic logic in_range(input node_t n);
        return n <= NODE_LAST;
    endfunction

    function automatic anc_addr_t anc_addr(input node_t n, input lvl_t l);
        return {n[AW-1:0], l[LW-1:0]};
    endfunction

    node_t anc_mem [ANC_DEPTH];
    node_t dep_mem [DEP_DEPTH];

    node_t nc_reg;
    node_t a_reg, b_reg, da_reg, db_reg, ancestor_reg;
    node_t anc0_rd_reg, anc1_rd_reg, dep_rd_reg;
    logic  anc0_ok_reg, anc1_ok_reg, dep_ok_reg;
    logic  s1_valid_reg, s2_valid_reg, s2_nz_reg;
    node_t s1_node_reg, s2_node_reg;

    node_t anc0_q, anc1_q, dep_q;
    node_t a_p1, a_p2, b_p2;
    logic  take1, take2;
    lvl_t  lvl_prev, top_raw;

    logic  anc_we, dep_we;
    node_t anc_wnode, anc_wdata, dep_wnode, dep_wdata;
    lvl_t  anc_wlvl;
    logic  anc0_re, anc1_re, dep_re;
    node_t anc0_node, anc1_node, dep_node;
    lvl_t  anc0_lvl, anc1_lvl;

    // out-of-range nodes read as zero
    assign anc0_q = anc0_ok_reg ? anc0_rd_reg : '0;
    assign anc1_q = anc1_ok_reg ? anc1_rd_reg : '0;
    assign dep_q  = dep_ok_reg  ? dep_rd_reg  : '0;

    assign take1 = dep_q >= db_reg;
    assign a_p1  = take1 ? anc0_q : a_reg;
    assign take2 = (anc0_q != '0) && (anc0_q != anc1_q);
    assign a_p2  = take2 ? anc0_q : a_reg;
    assign b_p2  = take2 ? anc1_q : b_reg;

    assign lvl_prev = cmd.level - lvl_t'(1);

    always_comb
    begin
        top_raw = '0;
        for (int i = 1; i < NODE_W; i++)
        begin
            if (nc_reg[i])
            begin
                top_raw = lvl_t'(i);
            end
        end
        stat.top_level = (top_raw > LEVEL_LAST) ? LEVEL_LAST : top_raw;
        stat.last_node = (nc_reg > NODE_LAST) ? NODE_LAST : nc_reg;
        stat.depth_ne  = da_reg != dep_q;
        stat.a_eq_b    = a_reg == b_reg;
    end

    always_comb
    begin
        anc_we    = 1'b0;
        anc_wnode = '0;
        anc_wlvl  = '0;
        anc_wdata = '0;
        dep_we    = 1'b0;
        dep_wnode = '0;
        dep_wdata = '0;
        anc0_re   = 1'b0;
        anc0_node = '0;
        anc0_lvl  = '0;
        anc1_re   = 1'b0;
        anc1_node = '0;
        anc1_lvl  = '0;
        dep_re    = 1'b0;
        dep_node  = '0;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                anc_we    = 1'b1;
                anc_wnode = cmd.node;
                anc_wlvl  = cmd.level;
                dep_we    = 1'b1;
                dep_wnode = cmd.node;
            end
            OP_LOAD:
            begin
                if ((node_a != '0) && in_range(node_a))
                begin
                    anc_we    = 1'b1;
                    anc_wnode = node_a;
                    anc_wdata = node_b;
                    dep_we    = 1'b1;
                    dep_wnode = node_a;
                    dep_wdata = node_depth;
                end
            end
            OP_RD_DA:
            begin
                dep_re   = 1'b1;
                dep_node = a_reg;
            end
            OP_RD_DB:
            begin
                dep_re   = 1'b1;
                dep_node = b_reg;
            end
            OP_L1_RD_ANC:
            begin
                anc0_re   = 1'b1;
                anc0_node = a_reg;
                anc0_lvl  = cmd.level;
            end
            OP_L1_RD_DEP:
            begin
                dep_re   = 1'b1;
                dep_node = anc0_q;
            end
            OP_L1_STEP:
            begin
                anc0_re   = 1'b1;
                anc0_node = a_p1;
                anc0_lvl  = cmd.level;
            end
            OP_P2_RD:
            begin
                anc0_re   = 1'b1;
                anc0_node = a_reg;
                anc0_lvl  = cmd.level;
                anc1_re   = 1'b1;
                anc1_node = b_reg;
                anc1_lvl  = cmd.level;
            end
            OP_P2_STEP:
            begin
                anc0_re   = 1'b1;
                anc0_node = a_p2;
                anc0_lvl  = cmd.level;
                anc1_re   = 1'b1;
                anc1_node = b_p2;
                anc1_lvl  = cmd.level;
            end
            OP_B_ISSUE:
            begin
                anc0_re   = 1'b1;
                anc0_node = cmd.node;
                anc0_lvl  = lvl_prev;
            end
            default:
            begin
            end
        endcase
        // build pipeline: second read through the mid node, then write back
        if (s1_valid_reg)
        begin
            anc1_re   = 1'b1;
            anc1_node = anc0_q;
            anc1_lvl  = lvl_prev;
        end
        if (s2_valid_reg)
        begin
            anc_we    = 1'b1;
            anc_wnode = s2_node_reg;
            anc_wlvl  = cmd.level;
            anc_wdata = s2_nz_reg ? anc1_q : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_addr(anc_wnode, anc_wlvl)] <= anc_wdata;
        end
        if (anc0_re)
        begin
            anc0_rd_reg <= anc_mem[anc_addr(anc0_node, anc0_lvl)];
            anc0_ok_reg <= in_range(anc0_node);
        end
        if (anc1_re)
        begin
            anc1_rd_reg <= anc_mem[anc_addr(anc1_node, anc1_lvl)];
            anc1_ok_reg <= in_range(anc1_node);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[dep_wnode[AW-1:0]] <= dep_wdata;
        end
        if (dep_re)
        begin
            dep_rd_reg <= dep_mem[dep_node[AW-1:0]];
            dep_ok_reg <= in_range(dep_node);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg       <= node_t'(1);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                nc_reg <= cfg_wdata;
            end
            s1_valid_reg <= cmd.op == OP_B_ISSUE;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_node_reg <= cmd.node;
        s2_node_reg <= s1_node_reg;
        s2_nz_reg   <= anc0_q != '0;
        unique case (cmd.op)
            OP_QCAPT:
            begin
                a_reg <= node_a;
                b_reg <= node_b;
            end
            OP_RD_DB:
            begin
                da_reg <= dep_q;
            end
            OP_SWAP:
            begin
                // keep the deeper node in a
                if (da_reg < dep_q)
                begin
                    a_reg  <= b_reg;
                    b_reg  <= a_reg;
                    db_reg <= da_reg;
                end
                else
                begin
                    db_reg <= dep_q;
                end
            end
            OP_L1_STEP:
            begin
                a_reg <= a_p1;
            end
            OP_P2_STEP:
            begin
                a_reg <= a_p2;
                b_reg <= b_p2;
            end
            OP_RES_A:
            begin
                ancestor_reg <= a_reg;
            end
            OP_RES_ANC:
            begin
                ancestor_reg <= anc0_q;
            end
            default:
            begin
            end
        endcase
    end

    assign ancestor = ancestor_reg;

endmodule

`default_nettype wire

@@ rtl/core/lca_ctrl.sv @@
// lca_ctrl: sequencer for clearing, load, table build and query, and the
// output word register flag. Uses lca_pkg; drives lca_datapath.
`default_nettype none

module lca_ctrl
    import lca_pkg::*;
#(
    parameter int MAX_NODES = 1023,
    parameter int LEVELS    = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [ACT_W-1:0] action,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire dp_stat_t         stat,
    output dp_cmd_t               cmd
);

    localparam node_t NODE_LAST  = node_last(MAX_NODES);
    localparam lvl_t  LEVEL_LAST = lvl_t'(LEVELS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QD0,
        S_QD1,
        S_QD2,
        S_L1_START,
        S_L1_D,
        S_L1_C,
        S_P2_START,
        S_P2_C,
        S_FIN,
        S_B_ISSUE,
        S_B_DRAIN0,
        S_B_DRAIN1
    } state_t;

    state_t state_reg, state_next;
    lvl_t   lvl_reg, lvl_next;
    node_t  node_reg, node_next;
    logic   out_valid_reg, out_valid_next;
    dp_op_t op;
    lvl_t   cmd_level, lvl_dec;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign lvl_dec  = (lvl_reg == '0) ? '0 : lvl_reg - lvl_t'(1);

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        node_next      = node_reg;
        out_valid_next = out_valid_reg && out_stall;
        op             = OP_NOP;
        cmd_level      = lvl_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLEAR;
                if (lvl_reg == LEVEL_LAST)
                begin
                    lvl_next = '0;
                    if (node_reg == NODE_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        node_next = node_reg + node_t'(1);
                    end
                end
                else
                begin
                    lvl_next = lvl_reg + lvl_t'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        ACT_LOAD:
                        begin
                            op = OP_LOAD;
                        end
                        ACT_QUERY:
                        begin
                            op         = OP_QCAPT;
                            state_next = S_QD0;
                        end
                        ACT_BUILD:
                        begin
                            if ((stat.top_level != '0) && (stat.last_node >= node_t'(2)))
                            begin
                                lvl_next   = lvl_t'(1);
                                node_next  = node_t'(2);
                                state_next = S_B_ISSUE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_QD0:
            begin
                op         = OP_RD_DA;
                state_next = S_QD1;
            end
            S_QD1:
            begin
                op         = OP_RD_DB;
                state_next = S_QD2;
            end
            S_QD2:
            begin
                op = OP_SWAP;
                if (stat.depth_ne)
                begin
                    lvl_next   = stat.top_level;
                    state_next = S_L1_START;
                end
                else
                begin
                    state_next = S_P2_START;
                end
            end
            S_L1_START:
            begin
                op         = OP_L1_RD_ANC;
                state_next = S_L1_D;
            end
            S_L1_D:
            begin
                op         = OP_L1_RD_DEP;
                state_next = S_L1_C;
            end
            S_L1_C:
            begin
                op        = OP_L1_STEP;
                cmd_level = lvl_dec;
                if (lvl_reg == '0)
                begin
                    state_next = S_P2_START;
                end
                else
                begin
                    lvl_next   = lvl_dec;
                    state_next = S_L1_D;
                end
            end
            S_P2_START:
            begin
                if (stat.a_eq_b)
                begin
                    if (out_free)
                    begin
                        op             = OP_RES_A;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    op         = OP_P2_RD;
                    cmd_level  = stat.top_level;
                    lvl_next   = stat.top_level;
                    state_next = S_P2_C;
                end
            end
            S_P2_C:
            begin
                // at level 0 this also reads the parent that is returned
                op        = OP_P2_STEP;
                cmd_level = lvl_dec;
                if (lvl_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    lvl_next = lvl_dec;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    op             = OP_RES_ANC;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_B_ISSUE:
            begin
                op = OP_B_ISSUE;
                if (node_reg == stat.last_node)
                begin
                    state_next = S_B_DRAIN0;
                end
                else
                begin
                    node_next = node_reg + node_t'(1);
                end
            end
            S_B_DRAIN0:
            begin
                state_next = S_B_DRAIN1;
            end
            S_B_DRAIN1:
            begin
                // last write of this level lands at the end of this cycle
                if (lvl_reg == stat.top_level)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + lvl_t'(1);
                    node_next  = node_t'(2);
                    state_next = S_B_ISSUE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            lvl_reg       <= '0;
            node_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            node_reg      <= node_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign cmd.op    = op;
    assign cmd.node  = node_reg;
    assign cmd.level = cmd_level;

endmodule

`default_nettype wire
